[design/decimal_year_time_converter_unit_defines.svh]
// Assertion macros for the converter's top-level RTL file.
// Each macro takes a label, the clock, the synchronous reset, an antecedent
// and a consequent. Synthesis sees empty bodies.
`ifndef DECIMAL_YEAR_TIME_CONVERTER_UNIT_DEFINES_SVH
`define DECIMAL_YEAR_TIME_CONVERTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define DYT_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed in decimal year converter");

// The consequent must hold in the cycle after the antecedent.
`define DYT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed in decimal year converter");

`else

`define DYT_ASSERT_SAME(label, clk, rst, ante, cons)

`define DYT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[design/dyt_pkg.sv]
`default_nettype none

package dyt_pkg;

  localparam int unsigned FRACTION_BITS_DEFAULT = 32;

  localparam int unsigned YEAR_W = 14;
  localparam int unsigned FRAC_W = 32;
  localparam int unsigned DAY_W  = 9;
  localparam int unsigned HOUR_W = 5;
  localparam int unsigned MIN_W  = 6;
  localparam int unsigned SEC_W  = 6;

  // Seconds in a year fit in 25 bits; elapsed seconds of a reverse
  // transaction, and twice a year's seconds, fit in 26 bits.
  localparam int unsigned SECS_YEAR_W = 25;
  localparam int unsigned ELAPSED_W   = 26;
  localparam int unsigned DAY_REM_W   = 17;
  localparam int unsigned HOUR_REM_W  = 12;

  localparam logic [SECS_YEAR_W-1:0] SECS_COMMON_YEAR = 25'd31536000;
  localparam logic [SECS_YEAR_W-1:0] SECS_LEAP_YEAR   = 25'd31622400;

  localparam int unsigned SECS_PER_DAY    = 86400;
  localparam int unsigned SECS_PER_HOUR   = 3600;
  localparam int unsigned SECS_PER_MINUTE = 60;

  // A year is a multiple of 25 exactly when its product with the inverse of
  // 25 modulo 2^14 is no greater than floor((2^14 - 1) / 25).
  localparam logic [YEAR_W-1:0] INV25_MOD_YEAR = 14'd7209;
  localparam logic [YEAR_W-1:0] DIV25_LIMIT    = 14'd655;

  typedef enum logic {
    OP_TO_CALENDAR = 1'b0,
    OP_TO_FRACTION = 1'b1
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [YEAR_W-1:0] year_in;
    logic [FRAC_W-1:0] fraction_in;
    logic [DAY_W-1:0]  day_in;
    logic [HOUR_W-1:0] hour_in;
    logic [MIN_W-1:0]  minute_in;
    logic [SEC_W-1:0]  second_in;
  } item_t;

  typedef struct packed {
    logic [YEAR_W-1:0] year_out;
    logic [FRAC_W-1:0] fraction_out;
    logic [DAY_W-1:0]  day_out;
    logic [HOUR_W-1:0] hour_out;
    logic [MIN_W-1:0]  minute_out;
    logic [SEC_W-1:0]  second_out;
  } result_t;

  // Load enables for the two register stages of a constant divider.
  typedef struct packed {
    logic stage_a;
    logic stage_b;
  } cdiv_load_t;

  // Side information that travels with every transaction.
  typedef struct packed {
    op_t               op;
    logic [YEAR_W-1:0] year;
    logic              leap;
    logic              sat;
  } side_t;

endpackage

`default_nettype wire

[design/dyt_cdiv.sv]
`default_nettype none

// Two-stage division by a constant: a reciprocal multiply that may fall
// one short, then a single compare-and-subtract correction.
module dyt_cdiv #(
  parameter int unsigned XW      = dyt_pkg::SECS_YEAR_W,
  parameter int unsigned DIVISOR = dyt_pkg::SECS_PER_DAY,
  parameter int unsigned QW      = dyt_pkg::DAY_W,
  parameter int unsigned RW      = dyt_pkg::DAY_REM_W
) (
  input  logic                clk,
  input  dyt_pkg::cdiv_load_t load,
  input  logic [XW-1:0]       x,
  output logic [QW-1:0]       q,
  output logic [RW-1:0]       r
);

  localparam longint unsigned RECIP = (64'd1 << XW) / DIVISOR;
  localparam int unsigned     MW    = $clog2(RECIP + 1);

  logic [XW+MW-1:0] prod;
  logic [XW-1:0]    x_a;
  logic [QW-1:0]    q0_a;
  logic [XW-1:0]    r0;
  logic             corr;

  assign prod = (XW+MW)'(x) * (XW+MW)'(RECIP);

  always_ff @(posedge clk) begin
    if (load.stage_a) begin
      x_a  <= x;
      q0_a <= QW'(prod >> XW);
    end
  end

  // The estimate is never above the true quotient and at most one below it.
  assign r0   = x_a - XW'(q0_a) * XW'(DIVISOR);
  assign corr = (r0 >= XW'(DIVISOR));

  always_ff @(posedge clk) begin
    if (load.stage_b) begin
      q <= q0_a + QW'(corr);
      r <= corr ? RW'(r0 - XW'(DIVISOR)) : RW'(r0);
    end
  end

endmodule

`default_nettype wire

[design/decimal_year_time_converter_unit.sv]
// Decimal year converter. Each transaction on the item channel carries an
// op code: OP_TO_CALENDAR turns a year and a binary fraction of that year
// into year, day of year, hour, minute and second, rounding half up to whole
// seconds and rolling a full year into the next one; OP_TO_FRACTION turns a
// calendar time into the truncated fraction of its year.
// Both channels use valid and stall: a transaction completes at a rising
// edge where valid is high and stall is low. Every item gives one result.
// result_valid rises once the transaction has passed through the nine
// register stages. Throughput is one transaction per cycle while
// result_stall is low: the stages advance independently, so a bubble
// anywhere is squeezed out and a new item is taken whenever the first stage
// is empty or moving on.
// When result_stall is high, the result holds and the stages behind it fill
// up; item_stall rises only once the first stage is occupied and cannot
// move. Reset (synchronous, active high) empties every stage at once;
// payload registers keep whatever they held. There is no configuration.
// The depth is set by the reverse long division (eight stages of a few
// restoring steps each) and, on the forward side, by three constant
// dividers of two stages each behind the 32 by 25 bit product.

`default_nettype none

`include "decimal_year_time_converter_unit_defines.svh"

module decimal_year_time_converter_unit #(
  parameter int unsigned FRACTION_BITS = dyt_pkg::FRACTION_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  dyt_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output dyt_pkg::result_t result
);

  localparam int unsigned STAGES     = 9;
  localparam int unsigned DIV_STAGES = STAGES - 1;
  // Restoring steps done in each division stage.
  localparam int unsigned RB = (FRACTION_BITS + DIV_STAGES - 1) / DIV_STAGES;
  localparam int unsigned FIN_W =
      (FRACTION_BITS < dyt_pkg::FRAC_W) ? FRACTION_BITS : dyt_pkg::FRAC_W;
  localparam int unsigned PW = FIN_W + dyt_pkg::SECS_YEAR_W + 1;
  localparam int unsigned TW = PW - FRACTION_BITS;
  localparam int unsigned CW = (TW > dyt_pkg::SECS_YEAR_W) ? TW : dyt_pkg::SECS_YEAR_W;
  localparam int unsigned RW = dyt_pkg::ELAPSED_W;
  localparam logic [PW-1:0] HALF = PW'(1) << (FRACTION_BITS - 1);

  // Stage valid bits and per-stage advance enables. A stage loads when it
  // is empty or when the stage after it loads too.
  logic [STAGES:1]   v;
  logic [STAGES:1]   v_in;
  logic [STAGES+1:1] en;

  dyt_pkg::side_t side [1:STAGES];

  // Stage 1: leap year test and elapsed seconds of the calendar time.
  logic [dyt_pkg::YEAR_W-1:0] y_mod;
  logic                       div25;
  logic                       leap1;
  logic [dyt_pkg::DAY_W-1:0]  day_m1;
  logic [RW-1:0]              elapsed;
  logic [RW-1:0]              elapsed1;
  logic [FIN_W-1:0]           f1;

  // Stage 2: forward product and the end-of-year check for reverse mode.
  logic [dyt_pkg::SECS_YEAR_W-1:0] s2;
  logic [PW-1:0]                   prod_next;
  logic [PW-1:0]                   prod2;
  logic                            sat_next;

  // Stage 3: whole seconds and the roll into the next year.
  logic [dyt_pkg::SECS_YEAR_W-1:0] s3;
  logic [CW-1:0]                   total_ext;
  logic                            roll;
  logic [dyt_pkg::SECS_YEAR_W-1:0] tot_next;
  logic [dyt_pkg::SECS_YEAR_W-1:0] tot3;

  // Reverse division remainders and quotients.
  logic [RW-1:0]            rem [2:STAGES];
  logic [FRACTION_BITS-1:0] quo [2:STAGES];

  // Calendar split through the constant dividers.
  dyt_pkg::cdiv_load_t            day_load, hour_load, min_load;
  logic [dyt_pkg::DAY_W-1:0]      day5, day6, day7, day8, day9;
  logic [dyt_pkg::DAY_REM_W-1:0]  dayrem5;
  logic [dyt_pkg::HOUR_W-1:0]     hour7, hour8, hour9;
  logic [dyt_pkg::HOUR_REM_W-1:0] hourrem7;
  logic [dyt_pkg::MIN_W-1:0]      min9;
  logic [dyt_pkg::SEC_W-1:0]      sec9;

  // ---------------------------------------------------------------------
  // Handshake and stage control.
  // ---------------------------------------------------------------------
  assign en[STAGES+1] = ~result_stall;

  for (genvar k = 1; k <= STAGES; k++) begin : g_en
    assign en[k] = ~v[k] | en[k+1];
  end

  assign v_in       = {v[STAGES-1:1], item_valid};
  assign item_stall = ~en[1];
  assign result_valid = v[STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 1; k <= STAGES; k++) begin
        if (en[k]) begin
          v[k] <= v_in[k];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1. Gregorian rule: a multiple of 4 that is either not a multiple
  // of 100 or a multiple of 400. Given a multiple of 4, that reduces to
  // "not a multiple of 25, or a multiple of 16".
  // ---------------------------------------------------------------------
  always_comb begin
    y_mod  = item.year_in * dyt_pkg::INV25_MOD_YEAR;
    div25  = (y_mod <= dyt_pkg::DIV25_LIMIT);
    leap1  = (item.year_in[1:0] == 2'b00) && (!div25 || (item.year_in[3:0] == 4'b0000));
    // Day zero counts as the first day.
    day_m1 = (item.day_in == '0) ? '0 : item.day_in - 1'b1;
    elapsed = RW'(day_m1) * RW'(dyt_pkg::SECS_PER_DAY)
            + RW'(item.hour_in) * RW'(dyt_pkg::SECS_PER_HOUR)
            + RW'(item.minute_in) * RW'(dyt_pkg::SECS_PER_MINUTE)
            + RW'(item.second_in);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      elapsed1 <= elapsed;
      f1       <= item.fraction_in[FIN_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2. The product keeps every bit, with one half added ahead of
  // the shift so that the shift rounds half up.
  // ---------------------------------------------------------------------
  always_comb begin
    s2        = side[1].leap ? dyt_pkg::SECS_LEAP_YEAR : dyt_pkg::SECS_COMMON_YEAR;
    prod_next = PW'(f1) * PW'(s2) + HALF;
    sat_next  = (elapsed1 >= RW'(s2));
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      prod2 <= prod_next;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3. A rounded count that reaches the year's length becomes the
  // first second of the next year; the year wraps at its field width.
  // ---------------------------------------------------------------------
  always_comb begin
    s3        = side[2].leap ? dyt_pkg::SECS_LEAP_YEAR : dyt_pkg::SECS_COMMON_YEAR;
    total_ext = CW'(prod2[PW-1:FRACTION_BITS]);
    roll      = (side[2].op == dyt_pkg::OP_TO_CALENDAR) && (total_ext >= CW'(s3));
    tot_next  = roll ? '0 : total_ext[dyt_pkg::SECS_YEAR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      tot3 <= tot_next;
    end
  end

  // Side information: the saturation flag joins at stage 2 and the year
  // carry at stage 3; elsewhere it simply moves along.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      side[1] <= '{op: dyt_pkg::op_t'(item.op), year: item.year_in, leap: leap1, sat: 1'b0};
    end
    if (en[2]) begin
      side[2] <= '{op: side[1].op, year: side[1].year, leap: side[1].leap, sat: sat_next};
    end
    if (en[3]) begin
      side[3] <= '{op: side[2].op, year: side[2].year + dyt_pkg::YEAR_W'(roll),
                   leap: side[2].leap, sat: side[2].sat};
    end
    for (int k = 4; k <= STAGES; k++) begin
      if (en[k]) begin
        side[k] <= side[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Reverse mode: restoring long division of the elapsed seconds by the
  // year's seconds, a few quotient bits in each of stages 2 to 9. When the
  // elapsed time reaches the year's length the quotient is not used.
  // ---------------------------------------------------------------------
  for (genvar j = 2; j <= STAGES; j++) begin : g_div
    logic [RW-1:0]                   r_in, r_out;
    logic [FRACTION_BITS-1:0]        q_in, q_out;
    logic [dyt_pkg::SECS_YEAR_W-1:0] s;

    if (j == 2) begin : g_first
      assign r_in = elapsed1;
      assign q_in = '0;
    end else begin : g_rest
      assign r_in = rem[j-1];
      assign q_in = quo[j-1];
    end

    assign s = side[j-1].leap ? dyt_pkg::SECS_LEAP_YEAR : dyt_pkg::SECS_COMMON_YEAR;

    always_comb begin
      r_out = r_in;
      q_out = q_in;
      for (int i = 0; i < RB; i++) begin
        if ((j - 2) * RB + i < FRACTION_BITS) begin
          r_out = {r_out[RW-2:0], 1'b0};
          q_out = {q_out[FRACTION_BITS-2:0], 1'b0};
          if (r_out >= RW'(s)) begin
            r_out    = r_out - RW'(s);
            q_out[0] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem[j] <= r_out;
        quo[j] <= q_out;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Forward mode: split the seconds into days (stages 4-5), hours
  // (stages 6-7), minutes and seconds (stages 8-9).
  // ---------------------------------------------------------------------
  assign day_load  = '{stage_a: en[4], stage_b: en[5]};
  assign hour_load = '{stage_a: en[6], stage_b: en[7]};
  assign min_load  = '{stage_a: en[8], stage_b: en[9]};

  dyt_cdiv #(
    .XW      (dyt_pkg::SECS_YEAR_W),
    .DIVISOR (dyt_pkg::SECS_PER_DAY),
    .QW      (dyt_pkg::DAY_W),
    .RW      (dyt_pkg::DAY_REM_W)
  ) u_day_div (
    .clk  (clk),
    .load (day_load),
    .x    (tot3),
    .q    (day5),
    .r    (dayrem5)
  );

  dyt_cdiv #(
    .XW      (dyt_pkg::DAY_REM_W),
    .DIVISOR (dyt_pkg::SECS_PER_HOUR),
    .QW      (dyt_pkg::HOUR_W),
    .RW      (dyt_pkg::HOUR_REM_W)
  ) u_hour_div (
    .clk  (clk),
    .load (hour_load),
    .x    (dayrem5),
    .q    (hour7),
    .r    (hourrem7)
  );

  dyt_cdiv #(
    .XW      (dyt_pkg::HOUR_REM_W),
    .DIVISOR (dyt_pkg::SECS_PER_MINUTE),
    .QW      (dyt_pkg::MIN_W),
    .RW      (dyt_pkg::SEC_W)
  ) u_min_div (
    .clk  (clk),
    .load (min_load),
    .x    (hourrem7),
    .q    (min9),
    .r    (sec9)
  );

  always_ff @(posedge clk) begin
    if (en[6]) begin
      day6 <= day5;
    end
    if (en[7]) begin
      day7 <= day6;
    end
    if (en[8]) begin
      day8  <= day7;
      hour8 <= hour7;
    end
    if (en[9]) begin
      day9  <= day8;
      hour9 <= hour8;
    end
  end

  // ---------------------------------------------------------------------
  // Result assembly from the last stage's registers, so it holds steady
  // while the receiver stalls.
  // ---------------------------------------------------------------------
  always_comb begin
    result          = '0;
    result.year_out = side[STAGES].year;
    if (side[STAGES].op == dyt_pkg::OP_TO_CALENDAR) begin
      result.day_out    = day9 + 1'b1;
      result.hour_out   = hour9;
      result.minute_out = min9;
      result.second_out = sec9;
    end else if (side[STAGES].sat) begin
      result.fraction_out = dyt_pkg::FRAC_W'({FRACTION_BITS{1'b1}});
    end else begin
      result.fraction_out = dyt_pkg::FRAC_W'(quo[STAGES]);
    end
  end

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  // The input side is held back only while the first stage is occupied.
  `DYT_ASSERT_SAME(a_stall_needs_occupancy, clk, rst, item_stall, v[1])

  // After the roll-over check, the second count lies inside its year.
  `DYT_ASSERT_SAME(a_seconds_within_year, clk, rst,
    v[3] && (side[3].op == dyt_pkg::OP_TO_CALENDAR),
    tot3 < (side[3].leap ? dyt_pkg::SECS_LEAP_YEAR : dyt_pkg::SECS_COMMON_YEAR))

  // A forward result is a proper calendar time whatever the input bits.
  `DYT_ASSERT_SAME(a_calendar_in_range, clk, rst,
    result_valid && (side[STAGES].op == dyt_pkg::OP_TO_CALENDAR),
    (result.day_out != '0) && (result.day_out <= 9'd366) && (result.hour_out < 5'd24)
      && (result.minute_out < 6'd60) && (result.second_out < 6'd60))

endmodule

`default_nettype wire

[tb/sv/decimal_year_time_converter_unit_test.sv]
// Testbench for the decimal year converter.
//
// The converter has no state and no configuration registers, so every
// transaction can be predicted on its own as soon as it is accepted. A small
// checker class holds a predictor written from the conversion rules. It keeps
// a queue of expected results in order of acceptance, and compares each
// accepted result with the oldest entry, field by field.
//
// Stimulus comes in two parts. A short directed part covers the corners:
// - fraction zero and all ones;
// - the roll-over into the next year, including the wrap of year 16383;
// - century years and year zero for the leap rule;
// - day zero and days past the end of the year;
// - hours, minutes and seconds above their normal ranges.
// A random part then follows in several phases, each with its own idling:
// - none;
// - the sender idle at random, with a chance of 57 in a hundred per try;
// - the receiver stalling at random, with a chance of 57 in a hundred;
// - both, with a chance of 6 in a hundred;
// - none again.
// Between phases the sender holds off until every expected result has come
// back, so the pipeline drains completely at least once mid-run.
//
// Inputs are driven with nonblocking assignments at the rising edge, and the
// monitors sample at the same edge. They therefore always see the values from
// before the edge, whatever order the processes run in.

`default_nettype none

module decimal_year_time_converter_unit_test;

  localparam int unsigned FRAC_BITS        = dyt_pkg::FRACTION_BITS_DEFAULT;
  localparam int unsigned ITEMS_PER_PHASE  = 150;
  localparam int unsigned PHASE_COUNT      = 5;
  localparam int unsigned REPORT_LIMIT     = 10;
  // The pipeline is nine stages deep; allow a good margin at the end.
  localparam int unsigned SETTLE_CYCLES    = 30;
  // Cycles without any accepted transaction before the run is abandoned.
  localparam int unsigned WATCHDOG_LIMIT   = 2000;

  // The checker predicts each conversion and compares the results in order.
  class conversion_checker;
    dyt_pkg::result_t expected_conversions[$];
    int unsigned      mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Works out the result of one transaction from the conversion rules.
    function dyt_pkg::result_t convert_timestamp(dyt_pkg::item_t it);
      dyt_pkg::result_t res;
      int unsigned      yr;
      logic             leap;
      logic [63:0]      secs_year;
      logic [63:0]      frac64;
      logic [63:0]      total;
      logic [63:0]      elapsed;
      logic [63:0]      day_num;
      res  = '0;
      yr   = 32'(it.year_in);
      leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
      secs_year = leap ? 64'(dyt_pkg::SECS_LEAP_YEAR) : 64'(dyt_pkg::SECS_COMMON_YEAR);
      if (it.op == dyt_pkg::OP_TO_CALENDAR) begin
        // Multiply the fraction out to seconds and round half up.
        frac64 = 64'(it.fraction_in);
        total  = (frac64 * secs_year + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        // A count that reaches the full year rolls into the next year.
        // The year field is 14 bits wide, so year 16383 wraps to zero.
        if (total >= secs_year) begin
          total = '0;
          yr    = yr + 1;
        end
        res.year_out   = yr[dyt_pkg::YEAR_W-1:0];
        res.day_out    = dyt_pkg::DAY_W'(total / dyt_pkg::SECS_PER_DAY + 1);
        res.hour_out   = dyt_pkg::HOUR_W'((total % dyt_pkg::SECS_PER_DAY)
                                          / dyt_pkg::SECS_PER_HOUR);
        res.minute_out = dyt_pkg::MIN_W'((total % dyt_pkg::SECS_PER_HOUR)
                                         / dyt_pkg::SECS_PER_MINUTE);
        res.second_out = dyt_pkg::SEC_W'(total % dyt_pkg::SECS_PER_MINUTE);
      end else begin
        // Day zero counts as the first day of the year.
        day_num = (it.day_in == '0) ? 64'd1 : 64'(it.day_in);
        elapsed = (day_num - 1) * dyt_pkg::SECS_PER_DAY
                + 64'(it.hour_in) * dyt_pkg::SECS_PER_HOUR
                + 64'(it.minute_in) * dyt_pkg::SECS_PER_MINUTE
                + 64'(it.second_in);
        res.year_out = it.year_in;
        // A time at or past the end of the year saturates the fraction.
        if (elapsed >= secs_year) begin
          res.fraction_out = '1;
        end else begin
          res.fraction_out = dyt_pkg::FRAC_W'((elapsed << FRAC_BITS) / secs_year);
        end
      end
      return res;
    endfunction

    function void note_item(dyt_pkg::item_t it);
      expected_conversions.push_back(convert_timestamp(it));
    endfunction

    function void check_result(dyt_pkg::result_t got);
      dyt_pkg::result_t want;
      if (expected_conversions.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("unexpected result: year %0d fraction %h day %0d time %0d:%0d:%0d",
                   got.year_out, got.fraction_out, got.day_out, got.hour_out,
                   got.minute_out, got.second_out);
        end
        return;
      end
      want = expected_conversions.pop_front();
      if (got.year_out !== want.year_out || got.fraction_out !== want.fraction_out ||
          got.day_out !== want.day_out || got.hour_out !== want.hour_out ||
          got.minute_out !== want.minute_out || got.second_out !== want.second_out) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("wrong result: expected year %0d fraction %h day %0d time %0d:%0d:%0d",
                   want.year_out, want.fraction_out, want.day_out, want.hour_out,
                   want.minute_out, want.second_out);
          $display("              got      year %0d fraction %h day %0d time %0d:%0d:%0d",
                   got.year_out, got.fraction_out, got.day_out, got.hour_out,
                   got.minute_out, got.second_out);
        end
      end
    endfunction
  endclass

  logic             clk          = 1'b0;
  logic             rst          = 1'b1;
  logic             item_valid   = 1'b0;
  logic             item_stall;
  dyt_pkg::item_t   item         = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  dyt_pkg::result_t result;

  conversion_checker board;
  int unsigned       receiver_stall_pct = 0;
  int unsigned       quiet_cycles       = 0;

  decimal_year_time_converter_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #6 clk = ~clk;

  // The receiver stalls at random, at the rate that the current phase sets.
  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  // Both channels are monitored at the edge where a transaction completes.
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) begin
        board.note_item(item);
      end
      if (result_valid && !result_stall) begin
        board.check_result(result);
      end
    end
  end

  // The watchdog restarts its count whenever either channel moves, so that
  // only a genuine hang, and not merely a long run, can trip it.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("decimal_year_time_converter_unit: mismatch");
      $finish;
    end
  end

  function automatic dyt_pkg::item_t calendar_item(int unsigned yr,
                                                   logic [dyt_pkg::FRAC_W-1:0] frac);
    dyt_pkg::item_t it;
    it             = '0;
    it.op          = dyt_pkg::OP_TO_CALENDAR;
    it.year_in     = dyt_pkg::YEAR_W'(yr);
    it.fraction_in = frac;
    return it;
  endfunction

  function automatic dyt_pkg::item_t fraction_item(int unsigned yr, int unsigned day,
                                                   int unsigned hr, int unsigned mn,
                                                   int unsigned sc);
    dyt_pkg::item_t it;
    it           = '0;
    it.op        = dyt_pkg::OP_TO_FRACTION;
    it.year_in   = dyt_pkg::YEAR_W'(yr);
    it.day_in    = dyt_pkg::DAY_W'(day);
    it.hour_in   = dyt_pkg::HOUR_W'(hr);
    it.minute_in = dyt_pkg::MIN_W'(mn);
    it.second_in = dyt_pkg::SEC_W'(sc);
    return it;
  endfunction

  // Random transactions are mostly well formed. A share of them carry
  // century years, fractions just short of a full year, days at the end of
  // the year, or time fields beyond their normal range. The fields that the
  // chosen mode does not use are filled at random as well.
  function automatic dyt_pkg::item_t random_item();
    dyt_pkg::item_t it;
    int unsigned    pick;
    it.op = ($urandom_range(1) == 1) ? dyt_pkg::OP_TO_FRACTION : dyt_pkg::OP_TO_CALENDAR;
    pick  = $urandom_range(9);
    if (pick == 0) begin
      it.year_in = dyt_pkg::YEAR_W'($urandom_range(16383));
    end else if (pick == 1) begin
      it.year_in = dyt_pkg::YEAR_W'($urandom_range(99) * 100);
    end else begin
      it.year_in = dyt_pkg::YEAR_W'($urandom_range(9999, 1));
    end
    pick = $urandom_range(7);
    if (pick == 0) begin
      it.fraction_in = 32'hFFFF_FFFF - $urandom_range(255);
    end else if (pick == 1) begin
      it.fraction_in = $urandom_range(4095);
    end else begin
      it.fraction_in = $urandom;
    end
    pick = $urandom_range(7);
    if (pick == 0) begin
      it.day_in = dyt_pkg::DAY_W'($urandom_range(511));
    end else if (pick == 1) begin
      it.day_in = dyt_pkg::DAY_W'($urandom_range(366, 365));
    end else begin
      it.day_in = dyt_pkg::DAY_W'($urandom_range(366, 1));
    end
    it.hour_in   = dyt_pkg::HOUR_W'(($urandom_range(9) == 0) ? $urandom_range(31)
                                                             : $urandom_range(23));
    it.minute_in = dyt_pkg::MIN_W'(($urandom_range(9) == 0) ? $urandom_range(63)
                                                            : $urandom_range(59));
    it.second_in = dyt_pkg::SEC_W'(($urandom_range(9) == 0) ? $urandom_range(63)
                                                            : $urandom_range(59));
    return it;
  endfunction

  // Offers one transaction and returns at the edge where it is accepted.
  // Valid stays high into the next call, so back-to-back transactions need
  // no gap; the payload holds for as long as the block stalls.
  task automatic send_item(input dyt_pkg::item_t it, input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
  endtask

  // Holds the sender off until every expected result has come back. The
  // first edge lets the monitor note the last accepted transaction.
  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (board.expected_conversions.size() != 0) @(posedge clk);
  endtask

  initial begin
    dyt_pkg::item_t corner_items[$];
    int unsigned    sender_idle_pct;

    board = new();

    // Forward corners: the ends of the fraction, roll-over with and without
    // the 14-bit wrap, and the leap rule for year zero and century years.
    corner_items.push_back(calendar_item(2000, 32'h0000_0000));
    corner_items.push_back(calendar_item(2000, 32'hFFFF_FFFF));
    corner_items.push_back(calendar_item(16383, 32'hFFFF_FFFF));
    corner_items.push_back(calendar_item(9999, 32'hFFFF_FFFF));
    corner_items.push_back(calendar_item(0, 32'h8000_0000));
    corner_items.push_back(calendar_item(1900, 32'h8000_0000));
    corner_items.push_back(calendar_item(400, 32'h4000_0000));
    corner_items.push_back(calendar_item(2024, 32'hFFFF_FF00));
    corner_items.push_back(calendar_item(2023, 32'h7FFF_FFFF));
    corner_items.push_back(calendar_item(9999, 32'h0000_0001));
    // Reverse corners: the start of the year, day zero, the last second of a
    // leap year, day 366 of a common year, and fields beyond their ranges.
    corner_items.push_back(fraction_item(2000, 1, 0, 0, 0));
    corner_items.push_back(fraction_item(2001, 0, 0, 0, 0));
    corner_items.push_back(fraction_item(2000, 366, 23, 59, 59));
    corner_items.push_back(fraction_item(2001, 366, 0, 0, 0));
    corner_items.push_back(fraction_item(2001, 365, 23, 59, 59));
    corner_items.push_back(fraction_item(1900, 511, 31, 63, 63));
    corner_items.push_back(fraction_item(2024, 1, 31, 63, 63));
    corner_items.push_back(fraction_item(0, 60, 12, 30, 30));
    corner_items.push_back(fraction_item(16383, 200, 5, 6, 7));
    corner_items.push_back(fraction_item(1, 1, 0, 0, 1));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (corner_items[i]) begin
      send_item(corner_items[i], 0);
    end
    wait_drained();

    // Random phases. Each ends with a full drain before the next begins.
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        1: begin
          sender_idle_pct    = 57;
          receiver_stall_pct <= 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct <= 57;
        end
        3: begin
          sender_idle_pct    = 6;
          receiver_stall_pct <= 6;
        end
        default: begin
          sender_idle_pct    = 0;
          receiver_stall_pct <= 0;
        end
      endcase
      repeat (ITEMS_PER_PHASE) send_item(random_item(), sender_idle_pct);
      wait_drained();
    end

    // Anything that turns up during the settling time is unexpected.
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (board.mismatches == 0 && board.expected_conversions.size() == 0) begin
      $display("decimal_year_time_converter_unit: match");
    end else begin
      $display("decimal_year_time_converter_unit: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
